FILE: design/lcmtd_pkg.sv
package lcmtd_pkg;

   localparam int MAX_VALUES_DEF = 8;
   localparam int VALUE_BITS_DEF = 32;
   localparam int LCM_BITS = 32;
   localparam int FIRST_DIVISOR = 2;

   typedef struct packed {
      logic load;
      logic start_run;
      logic pass_start;
      logic div_start;
      logic commit;
      logic mul_start;
      logic bump;
      logic result_load;
   } cmd_type;

   typedef struct packed {
      logic saw_zero;
      logic entry_big;
      logic div_done;
      logic last_entry;
      logic any_big;
      logic divided;
      logic mul_done;
   } status_type;

endpackage

FILE: design/lcmtd_if.sv
interface lcmtd_req_if #(
   parameter int VALUE_BITS = lcmtd_pkg::VALUE_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;
   logic                         is_last;

   modport source (output valid, output value, output is_last, input ready);
   modport sink (input valid, input value, input is_last, output ready);
endinterface

interface lcmtd_rsp_if;
   import lcmtd_pkg::*;

   logic                valid;
   logic                ready;
   logic [LCM_BITS-1:0] lcm;
   logic                overflow;

   modport source (output valid, output lcm, output overflow, input ready);
   modport sink (input valid, input lcm, input overflow, output ready);
endinterface

FILE: design/lcmtd_divider.sv
module lcmtd_divider #(
   parameter int VALUE_BITS = lcmtd_pkg::VALUE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-2:0] dividend,
   input  logic [VALUE_BITS-1:0] divisor,
   output logic                  done,
   output logic [VALUE_BITS-2:0] quotient,
   output logic [VALUE_BITS-1:0] remainder
);
   import lcmtd_pkg::*;

   localparam int DVD_BITS = VALUE_BITS - 1;
   localparam int CNT_W = $clog2(DVD_BITS + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DVD_BITS-1:0]   dvd_ff, dvd_in;
   logic [VALUE_BITS-1:0] rem_ff, rem_in;
   logic [VALUE_BITS-1:0] dsr_ff, dsr_in;
   logic [VALUE_BITS:0]   trial;
   logic [VALUE_BITS:0]   diff;
   logic                  fits;

   // One quotient bit per cycle; the quotient shifts into the dividend register.
   always_comb begin
      trial = {rem_ff, dvd_ff[DVD_BITS-1]};
      diff = trial - {1'b0, dsr_ff};
      fits = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = CNT_W'(DVD_BITS);
         dvd_in = dividend;
         rem_in = '0;
         dsr_in = divisor;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[DVD_BITS-2:0], fits};
         rem_in = fits ? diff[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done = done_ff;
   assign quotient = dvd_ff;
   assign remainder = rem_ff;

`ifndef ASSERT_OFF
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < dsr_ff))
      else $error("divider remainder not below divisor");

   a_done_single: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done lasted more than one cycle");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider started while busy");
`endif

endmodule

FILE: design/lcmtd_datapath.sv
module lcmtd_datapath #(
   parameter int MAX_VALUES = lcmtd_pkg::MAX_VALUES_DEF,
   parameter int VALUE_BITS = lcmtd_pkg::VALUE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  lcmtd_pkg::cmd_type              cmd,
   output lcmtd_pkg::status_type           status,
   input  logic signed [VALUE_BITS-1:0]    req_value,
   output logic [lcmtd_pkg::LCM_BITS-1:0]  rsp_lcm,
   output logic                            rsp_overflow
);
   import lcmtd_pkg::*;

   localparam int IDX_W = (MAX_VALUES > 1) ? $clog2(MAX_VALUES) : 1;
   localparam int CNT_W = $clog2(MAX_VALUES + 1);
   localparam int MAG_BITS = VALUE_BITS - 1;
   localparam int MBIT_W = $clog2(VALUE_BITS);

   logic [MAG_BITS-1:0]     store_mem [MAX_VALUES];
   logic [MAG_BITS-1:0]     rd_data_ff;

   logic [IDX_W-1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]        loaded_count_ff, loaded_count_in;
   logic                    saw_zero_ff, saw_zero_in;
   logic [VALUE_BITS-1:0]   divisor_ff, divisor_in;
   logic [VALUE_BITS-1:0]   product_ff, product_in;
   logic                    ovf_ff, ovf_in;
   logic                    any_big_ff, any_big_in;
   logic                    divided_ff, divided_in;
   logic                    all_prime_ff, all_prime_in;
   logic [MAG_BITS-1:0]     smallest_ff, smallest_in;
   logic [2*VALUE_BITS-1:0] mul_acc_ff, mul_acc_in;
   logic [MBIT_W-1:0]       mul_cnt_ff, mul_cnt_in;
   logic                    mul_busy_ff, mul_busy_in;
   logic                    mul_done_ff, mul_done_in;
   logic [LCM_BITS-1:0]     lcm_ff, lcm_in;
   logic                    ovf_out_ff, ovf_out_in;

   logic [VALUE_BITS-1:0]   raw;
   logic [VALUE_BITS-1:0]   mag_full;
   logic [MAG_BITS-1:0]     mag;
   logic                    room;
   logic                    wr_en;
   logic [IDX_W-1:0]        wr_addr;
   logic [MAG_BITS-1:0]     wr_data;
   logic                    rd_big;
   logic                    div_done;
   logic [MAG_BITS-1:0]     quotient;
   logic [VALUE_BITS-1:0]   remainder;
   logic [LCM_BITS+VALUE_BITS-1:0] lcm_wide;

   lcmtd_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (rd_data_ff),
      .divisor   (divisor_ff),
      .done      (div_done),
      .quotient  (quotient),
      .remainder (remainder)
   );

   // The most negative input has no positive twin, so it saturates.
   always_comb begin
      raw = req_value;
      mag_full = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
      mag = mag_full[VALUE_BITS-1] ? {MAG_BITS{1'b1}} : mag_full[MAG_BITS-1:0];
   end

   assign room = loaded_count_ff < CNT_W'(MAX_VALUES);
   assign rd_big = rd_data_ff > MAG_BITS'(1);
   assign lcm_wide = {{LCM_BITS{1'b0}}, product_ff};

   always_comb begin
      wr_en = 1'b0;
      wr_addr = idx_ff;
      wr_data = quotient;
      if (cmd.load && room) begin
         wr_en = 1'b1;
         wr_addr = loaded_count_ff[IDX_W-1:0];
         wr_data = mag;
      end else if (cmd.commit && rd_big && remainder == '0) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[idx_ff];
   end

   always_comb begin
      idx_in = idx_ff;
      loaded_count_in = loaded_count_ff;
      saw_zero_in = saw_zero_ff;
      divisor_in = divisor_ff;
      product_in = product_ff;
      ovf_in = ovf_ff;
      any_big_in = any_big_ff;
      divided_in = divided_ff;
      all_prime_in = all_prime_ff;
      smallest_in = smallest_ff;
      mul_acc_in = mul_acc_ff;
      mul_cnt_in = mul_cnt_ff;
      mul_busy_in = mul_busy_ff;
      mul_done_in = 1'b0;
      lcm_in = lcm_ff;
      ovf_out_in = ovf_out_ff;

      if (cmd.load && room) begin
         loaded_count_in = loaded_count_ff + CNT_W'(1);
         if (mag == '0) begin
            saw_zero_in = 1'b1;
         end
      end

      if (cmd.start_run) begin
         divisor_in = VALUE_BITS'(FIRST_DIVISOR);
         product_in = VALUE_BITS'(1);
         ovf_in = 1'b0;
      end

      if (cmd.pass_start) begin
         idx_in = '0;
         any_big_in = 1'b0;
         divided_in = 1'b0;
         all_prime_in = 1'b1;
         smallest_in = '0;
      end

      // Entries of one or less take no part in the pass.
      if (cmd.commit) begin
         idx_in = idx_ff + IDX_W'(1);
         if (rd_big) begin
            any_big_in = 1'b1;
            if (remainder == '0) begin
               divided_in = 1'b1;
            end
            if (divisor_ff <= {1'b0, quotient}) begin
               all_prime_in = 1'b0;
            end
            if (smallest_ff == '0 || rd_data_ff < smallest_ff) begin
               smallest_in = rd_data_ff;
            end
         end
      end

      // When every remaining number is prime, skip straight to the smallest.
      if (cmd.bump) begin
         if (all_prime_ff && {1'b0, smallest_ff} > divisor_ff) begin
            divisor_in = {1'b0, smallest_ff};
         end else begin
            divisor_in = divisor_ff + VALUE_BITS'(1);
         end
      end

      // Shift-and-add multiply, divisor bits from the top down.
      if (cmd.mul_start) begin
         mul_acc_in = '0;
         mul_cnt_in = MBIT_W'(VALUE_BITS - 1);
         mul_busy_in = 1'b1;
      end else if (mul_busy_ff) begin
         mul_acc_in = {mul_acc_ff[2*VALUE_BITS-2:0], 1'b0}
                      + (divisor_ff[mul_cnt_ff] ? {{VALUE_BITS{1'b0}}, product_ff} : '0);
         if (mul_cnt_ff == '0) begin
            mul_busy_in = 1'b0;
            mul_done_in = 1'b1;
            product_in = mul_acc_in[VALUE_BITS-1:0];
            ovf_in = ovf_ff | (|mul_acc_in[2*VALUE_BITS-1:VALUE_BITS]);
         end else begin
            mul_cnt_in = mul_cnt_ff - MBIT_W'(1);
         end
      end

      if (cmd.result_load) begin
         lcm_in = saw_zero_ff ? '0 : lcm_wide[LCM_BITS-1:0];
         ovf_out_in = saw_zero_ff ? 1'b0 : ovf_ff;
         loaded_count_in = '0;
         saw_zero_in = 1'b0;
         divisor_in = VALUE_BITS'(FIRST_DIVISOR);
         product_in = VALUE_BITS'(1);
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
         loaded_count_ff <= '0;
         saw_zero_ff <= 1'b0;
         divisor_ff <= VALUE_BITS'(FIRST_DIVISOR);
         product_ff <= VALUE_BITS'(1);
         ovf_ff <= 1'b0;
         any_big_ff <= 1'b0;
         divided_ff <= 1'b0;
         all_prime_ff <= 1'b1;
         smallest_ff <= '0;
         mul_cnt_ff <= '0;
         mul_busy_ff <= 1'b0;
         mul_done_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         loaded_count_ff <= loaded_count_in;
         saw_zero_ff <= saw_zero_in;
         divisor_ff <= divisor_in;
         product_ff <= product_in;
         ovf_ff <= ovf_in;
         any_big_ff <= any_big_in;
         divided_ff <= divided_in;
         all_prime_ff <= all_prime_in;
         smallest_ff <= smallest_in;
         mul_cnt_ff <= mul_cnt_in;
         mul_busy_ff <= mul_busy_in;
         mul_done_ff <= mul_done_in;
      end
      mul_acc_ff <= mul_acc_in;
      lcm_ff <= lcm_in;
      ovf_out_ff <= ovf_out_in;
   end

   always_comb begin
      status.saw_zero = saw_zero_ff;
      status.entry_big = rd_big;
      status.div_done = div_done;
      status.last_entry = (CNT_W'(idx_ff) + CNT_W'(1)) == loaded_count_ff;
      status.any_big = any_big_ff;
      status.divided = divided_ff;
      status.mul_done = mul_done_ff;
   end

   assign rsp_lcm = lcm_ff;
   assign rsp_overflow = ovf_out_ff;

`ifndef ASSERT_OFF
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      loaded_count_ff <= CNT_W'(MAX_VALUES))
      else $error("loaded count beyond store depth");

   a_div_only_big: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> rd_big)
      else $error("division started on an entry of one or less");

   a_bump_grows: assert property (@(posedge clock) disable iff (reset)
      cmd.bump |=> divisor_ff > $past(divisor_ff))
      else $error("trial divisor did not grow");
`endif

endmodule

FILE: design/lcmtd_ctrl.sv
module lcmtd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_is_last,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lcmtd_pkg::cmd_type    cmd,
   input  lcmtd_pkg::status_type status
);
   import lcmtd_pkg::*;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_START,
      ST_PASS,
      ST_READ,
      ST_CHECK,
      ST_DIV,
      ST_COMMIT,
      ST_DECIDE,
      ST_MUL,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_free;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_is_last) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            if (status.saw_zero) begin
               state_in = ST_RESULT;
            end else begin
               cmd.start_run = 1'b1;
               state_in = ST_PASS;
            end
         end
         ST_PASS: begin
            cmd.pass_start = 1'b1;
            state_in = ST_READ;
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.entry_big) begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end else begin
               cmd.commit = 1'b1;
               state_in = status.last_entry ? ST_DECIDE : ST_READ;
            end
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = status.last_entry ? ST_DECIDE : ST_READ;
         end
         ST_DECIDE: begin
            if (!status.any_big) begin
               state_in = ST_RESULT;
            end else if (status.divided) begin
               cmd.mul_start = 1'b1;
               state_in = ST_MUL;
            end else begin
               cmd.bump = 1'b1;
               state_in = ST_PASS;
            end
         end
         ST_MUL: begin
            if (status.mul_done) begin
               state_in = ST_PASS;
            end
         end
         ST_RESULT: begin
            if (rsp_free) begin
               cmd.result_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.start_run, cmd.pass_start, cmd.div_start,
                cmd.commit, cmd.mul_start, cmd.bump, cmd.result_load}))
      else $error("more than one datapath command at once");

   a_result_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.result_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result written over an untaken result");

   a_mul_needs_division: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> (status.divided && status.any_big))
      else $error("multiply started without a dividing pass");
`endif

endmodule

FILE: design/lcm_trial_division.sv
// Least common multiple of a set of signed numbers by trial division.
// Requests arrive on req_ch, one number each; is_last closes the set. Each
// number is stored as its magnitude (the most negative value saturates).
// Up to MAX_VALUES numbers are kept; further ones are dropped, but a dropped
// request with is_last still closes the set. One result leaves on rsp_ch per
// closed set: lcm (low 32 bits of the product) and an overflow flag. A zero
// in the set gives lcm = 0 with overflow clear.
// Loading takes one request per cycle. After the closing request the block
// accepts nothing until its result sits in the output register. A run
// passes a start state and a result state; between them it sweeps the
// store once per pass, opening with a pass state and closing with a decide
// state. An entry of one or less is read and checked; a larger one also
// runs through the bit-serial divider. A pass that divides some entry ends
// in a shift-add multiply and the same divisor is tried again; else the
// divisor grows. A set containing zero skips the passes and goes to its result.
// A stalled receiver holds the result; the next set loads meanwhile, and a
// second result waits until the first is taken.
// Reset is synchronous and clears all control state; store contents are
// not cleared and only loaded entries are ever read.
module lcm_trial_division #(
   parameter int MAX_VALUES = lcmtd_pkg::MAX_VALUES_DEF,
   parameter int VALUE_BITS = lcmtd_pkg::VALUE_BITS_DEF
) (
   input logic       clock,
   input logic       reset,
   lcmtd_req_if.sink   req_ch,
   lcmtd_rsp_if.source rsp_ch
);
   import lcmtd_pkg::*;

   cmd_type    cmd;
   status_type status;

   lcmtd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_is_last (req_ch.is_last),
      .req_ready   (req_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .cmd         (cmd),
      .status      (status)
   );

   lcmtd_datapath #(
      .MAX_VALUES (MAX_VALUES),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_value    (req_ch.value),
      .rsp_lcm      (rsp_ch.lcm),
      .rsp_overflow (rsp_ch.overflow)
   );

endmodule
